FILE: rtl/core/lfrb_pkg.sv
// Shared types and constants for the long flat run blanker.
// No dependencies; imported by every module of the block.
package lfrb_pkg;

  localparam int LFRB_MAX_SAMPLES = 2048;

  localparam int SAMPLE_W   = 16;
  localparam int EDGE_W     = 4;
  localparam int THR_W      = 16;
  localparam int MINRUN_W   = 11;
  localparam int RANGE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MARGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX   = 2'd3;

  localparam logic [EDGE_W-1:0]   EDGE_MARGIN_RST = 4'd2;
  localparam logic [THR_W-1:0]    STEP_THR_RST    = 16'd50;
  localparam logic [MINRUN_W-1:0] MIN_RUN_RST     = 11'd40;
  localparam logic [RANGE_W-1:0]  RANGE_MAX_RST   = 16'd30000;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_PRIME,
    OP_FETCH,
    OP_STEP,
    OP_TAIL,
    OP_BLANK,
    OP_CAPTURE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic rd_avail;
    logic loop_now;
    logic step_more;
    logic brk;
    logic long_run;
    logic blank_last;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [EDGE_W-1:0]   edge_margin;
    logic [THR_W-1:0]    step_threshold_mm;
    logic [MINRUN_W-1:0] min_run_length;
    logic [RANGE_W-1:0]  range_max_mm;
  } cfg_t;

endpackage

FILE: rtl/core/lfrb_ctrl.sv
// Sequencer for the run blanker: input handshake, filter walk and drain.
// Depends on lfrb_pkg; drives lfrb_datapath through cmd_t / stat_t.
module lfrb_ctrl import lfrb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  req_type,
  input  logic  last_sample,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_FETCH,
    S_STEP,
    S_BLANK_RUN,
    S_TAIL,
    S_BLANK_TAIL,
    S_READ
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_LOAD) begin
            cmd.op = OP_LOAD;
            if (last_sample) state_next = S_PRIME;
          end else begin
            cmd.op = OP_READ;
            if (stat.rd_avail) state_next = S_READ;
          end
        end
      end
      S_PRIME: begin
        cmd.op     = OP_PRIME;
        state_next = stat.loop_now ? S_FETCH : S_IDLE;
      end
      S_FETCH: begin
        cmd.op     = OP_FETCH;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.op = OP_STEP;
        if (stat.brk && stat.long_run) state_next = S_BLANK_RUN;
        else if (stat.step_more)       state_next = S_STEP;
        else                           state_next = S_TAIL;
      end
      S_BLANK_RUN: begin
        cmd.op = OP_BLANK;
        if (stat.blank_last) state_next = stat.loop_now ? S_STEP : S_TAIL;
      end
      S_TAIL: begin
        cmd.op     = OP_TAIL;
        state_next = stat.long_run ? S_BLANK_TAIL : S_IDLE;
      end
      S_BLANK_TAIL: begin
        cmd.op = OP_BLANK;
        if (stat.blank_last) state_next = S_IDLE;
      end
      S_READ: begin
        if (stat.out_free) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/lfrb_datapath.sv
// Datapath of the run blanker: sample and mark memories, scan counters,
// neighbor compare, blanking pointer and output register. Depends on lfrb_pkg.
module lfrb_datapath import lfrb_pkg::*; #(
  parameter int MAX_SAMPLES = LFRB_MAX_SAMPLES
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  cfg_t                cfg,
  input  logic [SAMPLE_W-1:0] sample_mm,
  input  logic                last_sample,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [RANGE_W-1:0]  range_mm,
  output logic                blanked,
  output logic                last_of_scan,
  output stat_t               stat
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = CW + 1;
  localparam int MW = (CW > MINRUN_W) ? CW : MINRUN_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

  logic [SAMPLE_W-1:0] sample_store [MAX_SAMPLES];
  logic                blank_marks  [MAX_SAMPLES];

  logic [CW-1:0]       wp;
  logic [CW-1:0]       rp;
  logic [CW-1:0]       len;
  logic [CW-1:0]       run;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       cnt;
  logic [AW-1:0]       bptr;
  logic [EDGE_W-1:0]   d_l;
  logic [THR_W-1:0]    thr_l;
  logic [MINRUN_W-1:0] min_l;
  logic [SAMPLE_W-1:0] prev;
  logic [SAMPLE_W-1:0] sq;
  logic                mq;
  logic                edge_r;
  logic                last_r;

  logic [CW-1:0]       wp_inc;
  logic [EDGE_W-1:0]   d_eff;
  logic [SW-1:0]       idx_ext;
  logic [SW-1:0]       d_ext;
  logic [SW-1:0]       len_ext;
  logic [SW-1:0]       rp_ext;
  logic [SAMPLE_W-1:0] diff;
  logic                edge_hit;
  logic [RANGE_W-1:0]  inf;
  logic [AW-1:0]       raddr;
  logic                sre;
  logic                rd_hit;
  logic                blk;

  assign wp_inc  = (wp < MAX_CNT) ? wp + CW'(1) : wp;
  assign d_eff   = (cfg.edge_margin == '0) ? EDGE_W'(1) : cfg.edge_margin;
  assign idx_ext = SW'(idx);
  assign d_ext   = SW'(d_l);
  assign len_ext = SW'(len);
  assign rp_ext  = SW'(rp);
  assign diff    = (prev >= sq) ? (prev - sq) : (sq - prev);
  assign inf     = (cfg.range_max_mm == '1) ? cfg.range_max_mm : cfg.range_max_mm + RANGE_W'(1);
  assign edge_hit = (rp_ext < d_ext) || ((rp_ext + d_ext) >= len_ext);
  assign rd_hit  = (cmd.op == OP_READ) && stat.rd_avail;
  assign blk     = edge_r || mq;

  assign stat.rd_avail   = (rp < len);
  assign stat.loop_now   = (idx_ext + d_ext) < len_ext;
  assign stat.step_more  = (idx_ext + d_ext + SW'(1)) < len_ext;
  assign stat.brk        = (diff > thr_l);
  assign stat.long_run   = (MW'(run) > MW'(min_l));
  assign stat.blank_last = (cnt == CW'(1));
  assign stat.out_free   = !out_valid || out_ready;

  always_comb begin
    raddr = AW'(rp);
    sre   = 1'b0;
    case (cmd.op)
      OP_PRIME: begin
        raddr = AW'(idx);
        sre   = 1'b1;
      end
      OP_FETCH: begin
        raddr = AW'(idx + CW'(1));
        sre   = 1'b1;
      end
      OP_STEP: begin
        raddr = AW'(idx + CW'(2));
        sre   = 1'b1;
      end
      OP_READ: begin
        raddr = AW'(rp);
        sre   = stat.rd_avail;
      end
      default: begin
        sre = 1'b0;
      end
    endcase
  end

  // sample memory
  always_ff @(posedge clk) begin
    if ((cmd.op == OP_LOAD) && (wp < MAX_CNT)) begin
      sample_store[AW'(wp)] <= sample_mm;
    end
    if (sre) begin
      sq <= sample_store[raddr];
    end
  end

  // blank mark memory
  always_ff @(posedge clk) begin
    if (cmd.op == OP_STEP) begin
      blank_marks[AW'(idx)] <= 1'b0;
    end else if (cmd.op == OP_BLANK) begin
      blank_marks[bptr] <= 1'b1;
    end
    if (rd_hit) begin
      mq <= blank_marks[AW'(rp)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      len       <= '0;
      run       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          if (wp == '0) begin
            len <= '0;
            rp  <= '0;
          end
          wp <= wp_inc;
          if (last_sample) begin
            len <= wp_inc;
            rp  <= '0;
            wp  <= '0;
            run <= '0;
          end
        end
        OP_READ: begin
          if (stat.rd_avail) rp <= rp + CW'(1);
        end
        OP_STEP: begin
          if (stat.brk) run <= '0;
          else          run <= run + CW'(1);
        end
        OP_TAIL: begin
          run <= '0;
        end
        default: begin
          run <= run;
        end
      endcase
      if (cmd.op == OP_CAPTURE) out_valid <= 1'b1;
      else if (out_ready)       out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        if (last_sample) begin
          d_l   <= d_eff;
          thr_l <= cfg.step_threshold_mm;
          min_l <= cfg.min_run_length;
          idx   <= CW'(d_eff);
        end
      end
      OP_FETCH: begin
        prev <= sq;
      end
      OP_STEP: begin
        idx  <= idx + CW'(1);
        prev <= sq;
        if (stat.brk) begin
          bptr <= AW'(idx - CW'(1));
          cnt  <= run;
        end
      end
      OP_TAIL: begin
        bptr <= AW'(len - CW'(d_l) - CW'(2));
        cnt  <= run;
      end
      OP_BLANK: begin
        bptr <= bptr - AW'(1);
        cnt  <= cnt - CW'(1);
      end
      OP_READ: begin
        if (stat.rd_avail) begin
          edge_r <= edge_hit;
          last_r <= ((rp + CW'(1)) == len);
        end
      end
      OP_CAPTURE: begin
        range_mm     <= blk ? inf : sq;
        blanked      <= blk;
        last_of_scan <= last_r;
      end
      default: begin
        prev <= prev;
      end
    endcase
  end

  a_rp_in_scan: assert property (@(posedge clk) disable iff (rst) rp <= len)
    else $error("read position beyond scan length");
  a_wp_bound: assert property (@(posedge clk) disable iff (rst) wp <= MAX_CNT)
    else $error("write position beyond store depth");
  a_blank_cnt: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_BLANK) |-> (cnt != '0))
    else $error("blank step with empty run count");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_STEP) |-> stat.loop_now)
    else $error("compare step outside inner range");

endmodule

FILE: rtl/core/long_flat_run_blanker.sv
// Long flat run blanker, top level: configuration registers, sequencer
// and datapath. Depends on lfrb_pkg, lfrb_ctrl and lfrb_datapath.
//
// A load transaction stores one sample and loads are taken back to back; the one
// that carries last_sample closes the scan and starts the filter walk. For a scan
// of at most 2d samples the walk is only the prime step; otherwise it runs prime,
// fetch, one compare step per inner sample and one blank step per blanked run
// sample, then the tail and its blanking, paced by the single write port of the
// blank mark memory and the single read port of the sample memory; no transaction
// is taken meanwhile. A read transaction passes through the memory read and then
// the output register, held back further only while that register is occupied.
// A read with nothing left to drain is taken in the idle state and gives no result.
module long_flat_run_blanker import lfrb_pkg::*; #(
  parameter int MAX_SAMPLES = LFRB_MAX_SAMPLES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [SAMPLE_W-1:0]   sample_mm,
  input  logic                  last_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RANGE_W-1:0]    range_mm,
  output logic                  blanked,
  output logic                  last_of_scan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_margin       <= EDGE_MARGIN_RST;
      cfg.step_threshold_mm <= STEP_THR_RST;
      cfg.min_run_length    <= MIN_RUN_RST;
      cfg.range_max_mm      <= RANGE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EDGE_MARGIN: cfg.edge_margin       <= cfg_data[EDGE_W-1:0];
        CFG_STEP_THR:    cfg.step_threshold_mm <= cfg_data[THR_W-1:0];
        CFG_MIN_RUN:     cfg.min_run_length    <= cfg_data[MINRUN_W-1:0];
        CFG_RANGE_MAX:   cfg.range_max_mm      <= cfg_data[RANGE_W-1:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  lfrb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .last_sample (last_sample),
    .stat        (stat),
    .cmd         (cmd)
  );

  lfrb_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .sample_mm    (sample_mm),
    .last_sample  (last_sample),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .range_mm     (range_mm),
    .blanked      (blanked),
    .last_of_scan (last_of_scan),
    .stat         (stat)
  );

endmodule

FILE: tb/tb_long_flat_run_blanker.sv
`timescale 1ns / 1ps
// Testbench for long_flat_run_blanker: loads random range scans, drains them and
// compares every result against an in-bench prediction of the run blanking.
// Depends on lfrb_pkg and the long_flat_run_blanker RTL.
module tb_long_flat_run_blanker;
  import lfrb_pkg::*;

  typedef struct packed {
    logic                req;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } scan_req_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               blanked;
    logic               last_of_scan;
  } range_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = REQ_LOAD;
  logic [SAMPLE_W-1:0]   sample_mm = '0;
  logic                  last_sample = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RANGE_W-1:0]    range_mm;
  logic                  blanked;
  logic                  last_of_scan;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_EDGE_MARGIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  long_flat_run_blanker i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .sample_mm    (sample_mm),
    .last_sample  (last_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .range_mm     (range_mm),
    .blanked      (blanked),
    .last_of_scan (last_of_scan),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  // Predicted block state
  int cfg_margin = int'(EDGE_MARGIN_RST);
  int cfg_thr    = int'(STEP_THR_RST);
  int cfg_minrun = int'(MIN_RUN_RST);
  int cfg_rmax   = int'(RANGE_MAX_RST);

  logic [SAMPLE_W-1:0] stored_mm [LFRB_MAX_SAMPLES];
  bit                  blank_mark [LFRB_MAX_SAMPLES];
  int scan_len = 0;
  int wr_pos   = 0;
  int rd_pos   = 0;

  range_result_t expected_ranges [$];
  scan_req_t     pending_reqs [$];
  int            mismatches = 0;

  task automatic report_mismatch(string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic void blank_walk(int n);
    int d;
    int runs;
    int a;
    int b;
    int diff;
    int k;
    d = (cfg_margin == 0) ? 1 : cfg_margin;
    for (int i = 0; i < n; i++) blank_mark[i] = 1'b1;
    for (int i = d; i < n - d; i++) blank_mark[i] = 1'b0;
    runs = 0;
    for (int i = d; i < n - d; i++) begin
      a = int'(stored_mm[i]);
      b = int'(stored_mm[i + 1]);
      diff = (a > b) ? a - b : b - a;
      if (diff > cfg_thr) begin
        if (runs > cfg_minrun) begin
          for (int j = 0; j < runs; j++) begin
            k = i - j - 1;
            if (k >= 0 && k < n) blank_mark[k] = 1'b1;
          end
        end
        runs = 0;
      end else begin
        runs++;
      end
    end
    if (runs > cfg_minrun) begin
      for (int j = 0; j < runs; j++) begin
        k = n - d - 2 - j;
        if (k >= 0 && k < n) blank_mark[k] = 1'b1;
      end
    end
  endfunction

  function automatic void predict_range_item(scan_req_t item);
    range_result_t res;
    logic [RANGE_W-1:0] inf;
    if (item.req == REQ_LOAD) begin
      if (wr_pos == 0) begin
        scan_len = 0;
        rd_pos = 0;
      end
      if (wr_pos < LFRB_MAX_SAMPLES) begin
        stored_mm[wr_pos] = item.sample;
        wr_pos++;
      end
      if (item.last) begin
        scan_len = wr_pos;
        rd_pos = 0;
        wr_pos = 0;
        blank_walk(scan_len);
      end
    end else if (rd_pos < scan_len) begin
      inf = (cfg_rmax >= 16'hFFFF) ? 16'hFFFF : RANGE_W'(cfg_rmax + 1);
      res.blanked = blank_mark[rd_pos];
      res.range_mm = res.blanked ? inf : stored_mm[rd_pos];
      res.last_of_scan = (rd_pos + 1 == scan_len);
      expected_ranges.insert(expected_ranges.size(), res);
      rd_pos++;
    end
  endfunction

  function automatic int draw_wait(inout bit idle_on);
    if ($urandom_range(0, 31) == 0) idle_on = !idle_on;
    return idle_on ? $urandom_range(0, 16) : 0;
  endfunction

  // Input driver
  scan_req_t held_req;
  bit        held_taken = 1'b0;
  int        in_gap = 0;
  bit        in_idle_on = 1'b1;

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predict_range_item(held_req);
      held_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || held_taken)) begin
      if (held_taken) begin
        held_taken = 1'b0;
        in_gap = draw_wait(in_idle_on);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        held_req = pending_reqs.pop_front();
        req_type <= held_req.req;
        sample_mm <= held_req.sample;
        last_sample <= held_req.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor
  bit out_taken = 1'b0;
  int out_stall = 0;
  bit out_idle_on = 1'b1;

  always @(posedge clk) begin
    range_result_t want;
    if (!rst && out_valid && out_ready) begin
      out_taken = 1'b1;
      if (expected_ranges.size() == 0) begin
        report_mismatch($sformatf("unexpected result range_mm=%0d", range_mm));
      end else begin
        want = expected_ranges.pop_front();
        if (range_mm !== want.range_mm)
          report_mismatch($sformatf("range_mm got %0d want %0d", range_mm, want.range_mm));
        if (blanked !== want.blanked)
          report_mismatch($sformatf("blanked got %b want %b", blanked, want.blanked));
        if (last_of_scan !== want.last_of_scan)
          report_mismatch($sformatf("last_of_scan got %b want %b",
                                    last_of_scan, want.last_of_scan));
      end
    end
  end

  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      out_stall = draw_wait(out_idle_on);
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Stimulus helpers
  task automatic push_load(logic [SAMPLE_W-1:0] value, logic is_last);
    scan_req_t item;
    item.req = REQ_LOAD;
    item.sample = value;
    item.last = is_last;
    pending_reqs.insert(pending_reqs.size(), item);
  endtask

  task automatic push_read();
    scan_req_t item;
    item.req = REQ_READ;
    item.sample = SAMPLE_W'($urandom_range(0, 65535));
    item.last = 1'($urandom_range(0, 1));
    pending_reqs.insert(pending_reqs.size(), item);
  endtask

  function automatic int next_sample(int prev, bit rough);
    int span;
    int delta;
    int v;
    if (rough || $urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
    span = (cfg_thr > 400) ? 400 : cfg_thr;
    delta = $urandom_range(0, span);
    if ($urandom_range(0, 7) == 0) delta = cfg_thr + 1 + $urandom_range(0, 50);
    v = $urandom_range(0, 1) ? prev + delta : prev - delta;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  task automatic push_scan(int n, bit rough, bit noisy);
    int v;
    v = $urandom_range(0, 65535);
    for (int k = 0; k < n; k++) begin
      v = next_sample(v, rough);
      push_load(SAMPLE_W'(v), k == n - 1);
      if (noisy && $urandom_range(0, 24) == 0) push_read();
    end
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    case (idx)
      CFG_EDGE_MARGIN: cfg_margin = val;
      CFG_STEP_THR:    cfg_thr = val;
      CFG_MIN_RUN:     cfg_minrun = val;
      CFG_RANGE_MAX:   cfg_rmax = val;
      default: ;
    endcase
  endtask

  task automatic write_config(int margin, int thr, int minrun, int rmax);
    set_reg(CFG_EDGE_MARGIN, margin & 'hF);
    set_reg(CFG_STEP_THR, thr & 'hFFFF);
    set_reg(CFG_MIN_RUN, minrun & 'h7FF);
    set_reg(CFG_RANGE_MAX, rmax & 'hFFFF);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // All transactions taken, all results back, then room for a filter walk.
  task automatic settle();
    int waited;
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    waited = 0;
    while (expected_ranges.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * LFRB_MAX_SAMPLES + 64) @(posedge clk);
  endtask

  task automatic run_random_phase(int target);
    int done;
    int n;
    int d;
    int reads;
    done = 0;
    d = (cfg_margin == 0) ? 1 : cfg_margin;
    while (done < target) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          repeat ($urandom_range(1, 3)) push_read();
        end else begin
          // unterminated loads run on into the next scan
          repeat ($urandom_range(1, 4)) push_load(SAMPLE_W'($urandom_range(0, 65535)), 1'b0);
        end
      end else begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 2 * d + 24);
        push_scan(n, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
        reads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 2);
        repeat (reads) push_read();
        done += n + reads;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: read before any scan, one-sample scan, overread
    push_read();
    push_load(16'hFFFF, 1'b1);
    push_read();
    push_read();
    settle();

    // Zero margin, zero threshold, zero run, saturated infinity
    write_config(0, 0, 0, 65535);
    push_load(16'h0000, 1'b0);
    push_load(16'h0000, 1'b0);
    push_load(16'h0000, 1'b0);
    push_load(16'hFFFF, 1'b0);
    push_load(16'hFFFF, 1'b0);
    push_load(16'hFFFF, 1'b0);
    push_load(16'h0007, 1'b0);
    push_load(16'h0007, 1'b1);
    repeat (4) push_read();
    // new scan cuts off the partly drained one
    push_load(16'h0001, 1'b0);
    push_load(16'h0002, 1'b0);
    push_load(16'h0003, 1'b1);
    repeat (4) push_read();
    settle();

    write_config(1, 0, 0, 0);
    run_random_phase(100);
    settle();

    write_config(15, 65535, 2047, 65534);
    run_random_phase(100);
    settle();

    write_config(2, 50, 40, 30000);
    run_random_phase(100);
    settle();

    repeat (5) begin
      write_config($urandom_range(0, 15),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300),
                   $urandom_range(0, 12), $urandom_range(0, 65535));
      run_random_phase(100);
      settle();
    end

    if (expected_ranges.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_ranges.size()));
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
